[design/sab_pkg.sv]
// Shared types, widths and constants for the sensor average/scale/BCD block.
// No dependencies; every other file except sab_cdiv refers to it by scoped names.
package sab_pkg;

  localparam int unsigned SAMPLE_W  = 10;
  localparam int unsigned VREF_W    = 12;
  localparam int unsigned MV_W      = 12;
  localparam int unsigned SUM_W     = 14;
  localparam int unsigned READING_W = 10;
  localparam int unsigned VOLTS_W   = 3;
  localparam int unsigned DIGIT_W   = 4;
  localparam int unsigned PROD_W    = SAMPLE_W + VREF_W;

  localparam int unsigned SAMPLE_COUNT_DEF = 10;
  localparam int unsigned FULL_SCALE_DEF   = 1023;

  localparam logic [VREF_W-1:0]    VREF_RESET  = 12'd3300;
  localparam logic [MV_W-1:0]      MV_MAX      = '1;
  localparam logic [SUM_W-1:0]     SUM_MAX     = '1;
  localparam logic [READING_W-1:0] READING_MAX = 10'd999;

  localparam int unsigned HUMID_DIVISOR = 33;
  localparam int unsigned TEMP_DIVISOR  = 10;
  localparam int unsigned THOUSAND      = 1000;
  localparam int unsigned HUNDRED       = 100;
  localparam int unsigned TEN           = 10;

  // Channel tag on samples and results.
  localparam logic KIND_HUMIDITY    = 1'b0;
  localparam logic KIND_TEMPERATURE = 1'b1;

  typedef struct packed {
    logic             kind;
    logic [SUM_W-1:0] value;
  } accum_beat_t;

  typedef struct packed {
    logic            kind;
    logic [MV_W-1:0] mv;
  } mv_beat_t;

endpackage

[design/sab_in_if.sv]
// Sample channel: valid/ready handshake carrying channel tag and raw sample.
// Depends on sab_pkg for field widths.
interface sab_in_if;
  logic                          valid;
  logic                          ready;
  logic                          operation;
  logic [sab_pkg::SAMPLE_W-1:0]  sample;

  modport source (output valid, operation, sample, input ready);
  modport sink   (input valid, operation, sample, output ready);
endinterface

[design/sab_out_if.sv]
// Result channel: valid/ready handshake carrying millivolts, reading and digits.
// Depends on sab_pkg for field widths.
interface sab_out_if;
  logic                           valid;
  logic                           ready;
  logic                           kind;
  logic [sab_pkg::MV_W-1:0]       millivolts;
  logic [sab_pkg::READING_W-1:0]  reading;
  logic [sab_pkg::VOLTS_W-1:0]    volts_digit;
  logic [sab_pkg::DIGIT_W-1:0]    tenths_digit;
  logic [sab_pkg::DIGIT_W-1:0]    hundredths_digit;
  logic [sab_pkg::DIGIT_W-1:0]    thousandths_digit;
  logic [sab_pkg::DIGIT_W-1:0]    reading_hundreds;
  logic [sab_pkg::DIGIT_W-1:0]    reading_tens;
  logic [sab_pkg::DIGIT_W-1:0]    reading_ones;

  modport source (output valid, kind, millivolts, reading, volts_digit, tenths_digit,
                  hundredths_digit, thousandths_digit, reading_hundreds, reading_tens,
                  reading_ones, input ready);
  modport sink   (input valid, kind, millivolts, reading, volts_digit, tenths_digit,
                  hundredths_digit, thousandths_digit, reading_hundreds, reading_tens,
                  reading_ones, output ready);
endinterface

[design/sab_cdiv.sv]
// Unsigned divide by an elaboration-time constant: one multiply by a rounded-up
// reciprocal and a shift, exact for every N-bit numerator. No dependencies.
module sab_cdiv #(
  parameter int unsigned N = 8,
  parameter int unsigned D = 1
) (
  input  logic [N-1:0] num,
  output logic [N-1:0] quo
);

  localparam int unsigned L  = $clog2(D);
  localparam int unsigned PW = 2 * N + 1;
  localparam logic [PW-1:0] POW = {{(PW-1){1'b0}}, 1'b1} << (N + L);
  localparam logic [PW-1:0] DW  = PW'(D);
  localparam logic [PW-1:0] MW  = (POW + DW - 1'b1) / DW;
  localparam logic [N:0]    M   = MW[N:0];

  logic [PW-1:0] prod;

  assign prod = {{(N+1){1'b0}}, num} * {{N{1'b0}}, M};
  assign quo  = N'(prod >> (N + L));

endmodule

[design/sab_accum.sv]
// Input stage: accepts samples, keeps the temperature sum and count, and
// registers one beat per humidity sample or per completed temperature batch.
// Depends on sab_pkg and sab_in_if.
module sab_accum #(
  parameter int unsigned SAMPLE_COUNT = sab_pkg::SAMPLE_COUNT_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  sab_in_if.sink               samples,
  output logic                 beat_valid,
  input  logic                 beat_ready,
  output sab_pkg::accum_beat_t beat
);

  localparam int unsigned CNT_W = $clog2(SAMPLE_COUNT + 1);

  logic [sab_pkg::SUM_W-1:0] sample_sum;
  logic [CNT_W-1:0]          sample_count;
  logic [sab_pkg::SUM_W:0]   sum_add;
  logic [sab_pkg::SUM_W-1:0] sum_sat;
  logic [CNT_W-1:0]          count_inc;
  logic                      last;
  logic                      accept;
  logic                      is_temp;

  assign samples.ready = !beat_valid || beat_ready;
  assign accept        = samples.valid && samples.ready;
  assign is_temp       = samples.operation == sab_pkg::KIND_TEMPERATURE;

  assign sum_add   = {1'b0, sample_sum} + (sab_pkg::SUM_W+1)'(samples.sample);
  assign sum_sat   = (sum_add > {1'b0, sab_pkg::SUM_MAX}) ? sab_pkg::SUM_MAX
                                                          : sum_add[sab_pkg::SUM_W-1:0];
  assign count_inc = sample_count + CNT_W'(1);
  assign last      = count_inc == CNT_W'(SAMPLE_COUNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_sum   <= '0;
      sample_count <= '0;
      beat_valid   <= 1'b0;
    end else begin
      if (samples.ready) begin
        beat_valid <= accept && (!is_temp || last);
      end
      if (accept && is_temp) begin
        if (last) begin
          sample_sum   <= '0;
          sample_count <= '0;
        end else begin
          sample_sum   <= sum_sat;
          sample_count <= count_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      beat.kind  <= samples.operation;
      beat.value <= is_temp ? sum_sat : sab_pkg::SUM_W'(samples.sample);
    end
  end

endmodule

[design/sab_scale.sv]
// Scaling pipeline: batch average, multiply by the reference voltage, divide
// by full scale and saturate to millivolts. Depends on sab_pkg and sab_cdiv.
module sab_scale #(
  parameter int unsigned SAMPLE_COUNT = sab_pkg::SAMPLE_COUNT_DEF,
  parameter int unsigned FULL_SCALE   = sab_pkg::FULL_SCALE_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [sab_pkg::VREF_W-1:0]  vref_mv,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  sab_pkg::accum_beat_t        in_beat,
  output logic                        out_valid,
  input  logic                        out_ready,
  output sab_pkg::mv_beat_t           out_beat
);

  logic                         va, vb;
  logic                         adv_a, adv_b, adv_c;
  logic                         kind_a, kind_b;
  logic [sab_pkg::SAMPLE_W-1:0] avg_a;
  logic [sab_pkg::PROD_W-1:0]   prod_b;
  logic [sab_pkg::SUM_W-1:0]    avg_q;
  logic [sab_pkg::PROD_W-1:0]   mv_q;

  assign adv_c    = !out_valid || out_ready;
  assign adv_b    = !vb || adv_c;
  assign adv_a    = !va || adv_b;
  assign in_ready = adv_a;

  sab_cdiv #(.N(sab_pkg::SUM_W), .D(SAMPLE_COUNT)) u_avg (
    .num (in_beat.value),
    .quo (avg_q)
  );

  sab_cdiv #(.N(sab_pkg::PROD_W), .D(FULL_SCALE)) u_fs (
    .num (prod_b),
    .quo (mv_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      vb        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv_a) va <= in_valid;
      if (adv_b) vb <= va;
      if (adv_c) out_valid <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_a && in_valid) begin
      kind_a <= in_beat.kind;
      avg_a  <= (in_beat.kind == sab_pkg::KIND_TEMPERATURE)
                ? sab_pkg::SAMPLE_W'(avg_q) : sab_pkg::SAMPLE_W'(in_beat.value);
    end
    if (adv_b && va) begin
      kind_b <= kind_a;
      prod_b <= sab_pkg::PROD_W'(avg_a) * sab_pkg::PROD_W'(vref_mv);
    end
    if (adv_c && vb) begin
      out_beat.kind <= kind_b;
      out_beat.mv   <= (mv_q > sab_pkg::PROD_W'(sab_pkg::MV_MAX)) ? sab_pkg::MV_MAX
                                                                  : sab_pkg::MV_W'(mv_q);
    end
  end

endmodule

[design/sab_smooth.sv]
// Smoothing stage: holds the last temperature millivolts and blends each new
// batch value with it; humidity beats pass unchanged. Depends on sab_pkg.
module sab_smooth (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  sab_pkg::mv_beat_t in_beat,
  output logic              out_valid,
  input  logic              out_ready,
  output sab_pkg::mv_beat_t out_beat
);

  logic [sab_pkg::MV_W-1:0] smoothed_mv;
  logic [sab_pkg::MV_W-1:0] smoothed_next;
  logic [sab_pkg::MV_W:0]   mean_sum;
  logic                     take;
  logic                     is_temp;

  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;
  assign is_temp  = in_beat.kind == sab_pkg::KIND_TEMPERATURE;

  // A stored zero means no history yet: take the new value as is.
  assign mean_sum      = {1'b0, in_beat.mv} + {1'b0, smoothed_mv};
  assign smoothed_next = (smoothed_mv == '0) ? in_beat.mv : mean_sum[sab_pkg::MV_W:1];

  always_ff @(posedge clk) begin
    if (rst) begin
      smoothed_mv <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (in_ready) out_valid <= in_valid;
      if (take && is_temp) smoothed_mv <= smoothed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_beat.kind <= in_beat.kind;
      out_beat.mv   <= is_temp ? smoothed_next : in_beat.mv;
    end
  end

endmodule

[design/sab_format.sv]
// Formatting pipeline: reading from millivolts, saturation, and decimal digit
// split over three stages. Depends on sab_pkg, sab_cdiv and sab_out_if.
module sab_format (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  sab_pkg::mv_beat_t in_beat,
  sab_out_if.source         results
);

  localparam int unsigned FRAC_W = 10;
  localparam int unsigned REM_W  = 7;

  logic                          ve, vf;
  logic                          adv_e, adv_f, adv_g;
  // stage E
  logic                          kind_e;
  logic [sab_pkg::MV_W-1:0]      mv_e;
  logic [sab_pkg::READING_W-1:0] reading_e;
  logic [sab_pkg::VOLTS_W-1:0]   volts_e;
  logic [FRAC_W-1:0]             frac_e;
  // stage F
  logic                          kind_f;
  logic [sab_pkg::MV_W-1:0]      mv_f;
  logic [sab_pkg::READING_W-1:0] reading_f;
  logic [sab_pkg::VOLTS_W-1:0]   volts_f;
  logic [sab_pkg::DIGIT_W-1:0]   frac_h_f, read_h_f;
  logic [REM_W-1:0]              frac_r_f, read_r_f;
  // combinational quotients
  logic [sab_pkg::MV_W-1:0]      div10_q, div33_q, div1000_q, reading_raw;
  logic [FRAC_W-1:0]             frac_c;
  logic [FRAC_W-1:0]             frac_hq, read_hq;
  logic [REM_W-1:0]              frac_tq, read_tq;

  assign adv_g    = !results.valid || results.ready;
  assign adv_f    = !vf || adv_g;
  assign adv_e    = !ve || adv_f;
  assign in_ready = adv_e;

  sab_cdiv #(.N(sab_pkg::MV_W), .D(sab_pkg::TEMP_DIVISOR)) u_div10 (
    .num (in_beat.mv), .quo (div10_q)
  );
  sab_cdiv #(.N(sab_pkg::MV_W), .D(sab_pkg::HUMID_DIVISOR)) u_div33 (
    .num (in_beat.mv), .quo (div33_q)
  );
  sab_cdiv #(.N(sab_pkg::MV_W), .D(sab_pkg::THOUSAND)) u_div1000 (
    .num (in_beat.mv), .quo (div1000_q)
  );
  sab_cdiv #(.N(FRAC_W), .D(sab_pkg::HUNDRED)) u_frac_h (
    .num (frac_e), .quo (frac_hq)
  );
  sab_cdiv #(.N(FRAC_W), .D(sab_pkg::HUNDRED)) u_read_h (
    .num (reading_e), .quo (read_hq)
  );
  sab_cdiv #(.N(REM_W), .D(sab_pkg::TEN)) u_frac_t (
    .num (frac_r_f), .quo (frac_tq)
  );
  sab_cdiv #(.N(REM_W), .D(sab_pkg::TEN)) u_read_t (
    .num (read_r_f), .quo (read_tq)
  );

  assign reading_raw = (in_beat.kind == sab_pkg::KIND_TEMPERATURE) ? div10_q : div33_q;
  assign frac_c      = FRAC_W'(in_beat.mv - div1000_q * sab_pkg::MV_W'(sab_pkg::THOUSAND));

  always_ff @(posedge clk) begin
    if (rst) begin
      ve            <= 1'b0;
      vf            <= 1'b0;
      results.valid <= 1'b0;
    end else begin
      if (adv_e) ve <= in_valid;
      if (adv_f) vf <= ve;
      if (adv_g) results.valid <= vf;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_e && in_valid) begin
      kind_e    <= in_beat.kind;
      mv_e      <= in_beat.mv;
      reading_e <= (reading_raw > sab_pkg::MV_W'(sab_pkg::READING_MAX))
                   ? sab_pkg::READING_MAX : sab_pkg::READING_W'(reading_raw);
      volts_e   <= sab_pkg::VOLTS_W'(div1000_q);
      frac_e    <= frac_c;
    end
    if (adv_f && ve) begin
      kind_f    <= kind_e;
      mv_f      <= mv_e;
      reading_f <= reading_e;
      volts_f   <= volts_e;
      frac_h_f  <= sab_pkg::DIGIT_W'(frac_hq);
      read_h_f  <= sab_pkg::DIGIT_W'(read_hq);
      frac_r_f  <= REM_W'(frac_e - frac_hq * FRAC_W'(sab_pkg::HUNDRED));
      read_r_f  <= REM_W'(reading_e - read_hq * FRAC_W'(sab_pkg::HUNDRED));
    end
    if (adv_g && vf) begin
      results.kind              <= kind_f;
      results.millivolts        <= mv_f;
      results.reading           <= reading_f;
      results.volts_digit       <= volts_f;
      results.tenths_digit      <= frac_h_f;
      results.hundredths_digit  <= sab_pkg::DIGIT_W'(frac_tq);
      results.thousandths_digit <= sab_pkg::DIGIT_W'(frac_r_f - frac_tq * REM_W'(sab_pkg::TEN));
      results.reading_hundreds  <= read_h_f;
      results.reading_tens      <= sab_pkg::DIGIT_W'(read_tq);
      results.reading_ones      <= sab_pkg::DIGIT_W'(read_r_f - read_tq * REM_W'(sab_pkg::TEN));
    end
  end

endmodule

[design/sensor_average_scale_bcd.sv]
// Sensor sample scaler with temperature batch averaging and BCD formatting.
// Throughput: one sample per cycle while results.ready is not held low; every
// pipeline stage advances on its own valid/ready, so bubbles (temperature
// samples without a result) absorb stalls. Reset (rst, synchronous): clears
// sum, count, smoothed value and all valids; vref returns to 3300 mV. Depends on
// sab_pkg, sab_in_if, sab_out_if, sab_accum, sab_scale, sab_smooth, sab_format.
module sensor_average_scale_bcd #(
  parameter int unsigned SAMPLE_COUNT = sab_pkg::SAMPLE_COUNT_DEF,
  parameter int unsigned FULL_SCALE   = sab_pkg::FULL_SCALE_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [sab_pkg::VREF_W-1:0] cfg_data,
  sab_in_if.sink                     samples,
  sab_out_if.source                  results
);

  // Reference voltage register; the user must write it only while the pipeline is idle
  // (the block does not enforce this), so no stage needs its own copy.
  logic [sab_pkg::VREF_W-1:0] vref_mv;

  // Inter-stage handshakes and payloads.
  logic                 acc_valid, acc_ready;
  sab_pkg::accum_beat_t acc_beat;
  logic                 scl_valid, scl_ready;
  sab_pkg::mv_beat_t    scl_beat;
  logic                 smo_valid, smo_ready;
  sab_pkg::mv_beat_t    smo_beat;

  always_ff @(posedge clk) begin
    if (rst) begin
      vref_mv <= sab_pkg::VREF_RESET;
    end else if (cfg_write) begin
      vref_mv <= cfg_data;
    end
  end

  // Stage 1: accumulate temperature batches, forward humidity samples.
  sab_accum #(.SAMPLE_COUNT(SAMPLE_COUNT)) u_accum (
    .clk        (clk),
    .rst        (rst),
    .samples    (samples),
    .beat_valid (acc_valid),
    .beat_ready (acc_ready),
    .beat       (acc_beat)
  );

  // Stages 2-4: average, multiply by vref, divide by full scale, saturate.
  sab_scale #(.SAMPLE_COUNT(SAMPLE_COUNT), .FULL_SCALE(FULL_SCALE)) u_scale (
    .clk       (clk),
    .rst       (rst),
    .vref_mv   (vref_mv),
    .in_valid  (acc_valid),
    .in_ready  (acc_ready),
    .in_beat   (acc_beat),
    .out_valid (scl_valid),
    .out_ready (scl_ready),
    .out_beat  (scl_beat)
  );

  // Stage 5: blend temperature with history; the feedback loop closes on the
  // smoothed register, so back-to-back batches need no interlock.
  sab_smooth u_smooth (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (scl_valid),
    .in_ready  (scl_ready),
    .in_beat   (scl_beat),
    .out_valid (smo_valid),
    .out_ready (smo_ready),
    .out_beat  (smo_beat)
  );

  // Stages 6-8: reading, saturation, digits; last stage is the output register.
  sab_format u_format (
    .clk      (clk),
    .rst      (rst),
    .in_valid (smo_valid),
    .in_ready (smo_ready),
    .in_beat  (smo_beat),
    .results  (results)
  );

  // Digits must recompose the binary fields they were split from.
  a_mv_digits: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> (int'(results.millivolts) ==
      int'(results.volts_digit) * 1000 + int'(results.tenths_digit) * 100 +
      int'(results.hundredths_digit) * 10 + int'(results.thousandths_digit)))
    else $error("millivolts digits do not match millivolts");

  a_reading_digits: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> (int'(results.reading) ==
      int'(results.reading_hundreds) * 100 + int'(results.reading_tens) * 10 +
      int'(results.reading_ones)))
    else $error("reading digits do not match reading");

  // Drop every beat in flight on reset.
  a_reset_flush: assert property (@(posedge clk) rst |=> !results.valid)
    else $error("result valid after reset");

endmodule
